[rtl/psdc_pkg.sv]
// Package: shared types, constants and register codes for the step detector.
`timescale 1ns / 1ps
`default_nettype none

package psdc_pkg;

  // Stamp history depth default
  localparam int PSDC_HISTORY_DEPTH = 16;

  // APB register file
  localparam int PSDC_ADDR_W = 4;
  localparam int PSDC_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic [14:0] PSDC_THRESHOLD_RST = 15'd1229;
  localparam logic [15:0] PSDC_REFRACTORY_RST = 16'd300;
  localparam logic [15:0] PSDC_WINDOW_RST = 16'd10000;
  localparam logic [15:0] PSDC_TIMEOUT_RST = 16'd3000;

  // Arithmetic constants
  localparam logic signed [16:0] PSDC_ONE_G = 17'sd4096;
  localparam logic [31:0] PSDC_MIN_SPAN_MS = 32'd200;
  localparam int PSDC_RATE_NUM = 120000;  // twice 60000 ms per minute
  localparam int PSDC_MIN_SPAN = 200;
  localparam int PSDC_DEN_W = 33;  // twice a 32-bit span
  localparam logic [7:0] PSDC_CAD_MAX = 8'd255;

  // Activity codes
  localparam logic [3:0] ACT_IDLE = 4'd0;
  localparam logic [3:0] ACT_WALK = 4'd1;
  localparam logic [3:0] ACT_RUN = 4'd2;
  localparam logic [3:0] ACT_STAIRS = 4'd3;
  localparam logic [3:0] ACT_FALL_LO = 4'd4;
  localparam logic [3:0] ACT_FALL_HI = 4'd7;

  // Register indexes
  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_REFRACTORY,
    REG_WINDOW,
    REG_TIMEOUT
  } psdc_reg_t;

  // Configuration register contents
  typedef struct packed {
    logic [14:0] step_threshold;
    logic [15:0] refractory_ms;
    logic [15:0] stamp_window_ms;
    logic [15:0] rate_timeout_ms;
  } psdc_cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRUNE_RD,
    ST_PRUNE_CMP,
    ST_CAD_NEW,
    ST_CAD_OLD,
    ST_CAD_SPAN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } psdc_state_t;

endpackage

`default_nettype wire

[rtl/psdc_if.sv]
// Interfaces: sample input channel and report output channel.
`timescale 1ns / 1ps
`default_nettype none

interface psdc_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] vertical_accel;
  logic [3:0] activity_code;
  logic [31:0] time_ms;

  modport source (output valid, output vertical_accel, output activity_code,
                  output time_ms, input ready);
  modport sink (input valid, input vertical_accel, input activity_code,
                input time_ms, output ready);
endinterface

interface psdc_report_if;
  logic valid;
  logic ready;
  logic step_counted;
  logic [31:0] step_total;
  logic [15:0] walk_total;
  logic [15:0] run_total;
  logic [15:0] stairs_total;
  logic [15:0] other_steps;
  logic [7:0] step_rate;

  modport source (output valid, output step_counted, output step_total,
                  output walk_total, output run_total, output stairs_total,
                  output other_steps, output step_rate, input ready);
  modport sink (input valid, input step_counted, input step_total,
                input walk_total, input run_total, input stairs_total,
                input other_steps, input step_rate, output ready);
endinterface

`default_nettype wire

[rtl/psdc_cfg.sv]
// APB configuration register file for the step detector.
`timescale 1ns / 1ps
`default_nettype none

module psdc_cfg
  import psdc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PSDC_ADDR_W-1:0] paddr,
  input  wire logic [PSDC_DATA_W-1:0] pwdata,
  output logic      [PSDC_DATA_W-1:0] prdata,
  output logic                        pready,
  output psdc_cfg_t                   cfg
);

  psdc_reg_t reg_sel;
  logic      wr_en;

  assign reg_sel = psdc_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_threshold  <= PSDC_THRESHOLD_RST;
      cfg.refractory_ms   <= PSDC_REFRACTORY_RST;
      cfg.stamp_window_ms <= PSDC_WINDOW_RST;
      cfg.rate_timeout_ms <= PSDC_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_THRESHOLD:  cfg.step_threshold  <= pwdata[14:0];
        REG_REFRACTORY: cfg.refractory_ms   <= pwdata[15:0];
        REG_WINDOW:     cfg.stamp_window_ms <= pwdata[15:0];
        REG_TIMEOUT:    cfg.rate_timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_THRESHOLD:  prdata = {17'd0, cfg.step_threshold};
      REG_REFRACTORY: prdata = {16'd0, cfg.refractory_ms};
      REG_WINDOW:     prdata = {16'd0, cfg.stamp_window_ms};
      REG_TIMEOUT:    prdata = {16'd0, cfg.rate_timeout_ms};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/psdc_ring.sv]
// Step stamp memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module psdc_ring #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [31:0]       wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [31:0]       rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/psdc_div.sv]
// Restoring divider, one quotient bit per cycle, for the cadence estimate.
`timescale 1ns / 1ps
`default_nettype none

module psdc_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 33,
  parameter int QUO_W = 15
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [QUO_W-1:0] quo
);

  localparam int DW = DEN_W + QUO_W - 1;
  localparam int RW = (NUM_W > DW) ? NUM_W : DW;
  localparam int CW = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          fits;

  assign fits = (rem >= dsh);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QUO_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: compare and subtract the shifted divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= RW'(num);
      dsh <= RW'(den) << (QUO_W - 1);
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QUO_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

[rtl/peak_step_detector_cadence_core.sv]
// Top level: peak-threshold step detector with activity gating and cadence.
`timescale 1ns / 1ps
`default_nettype none

// Takes one acceleration sample at a time and returns one report per sample.
// Peak tracking and counting are registered as the sample is taken. The core
// then prunes stale stamps from the stamp memory with a read state and a
// compare state per stamp examined, reads the newest and oldest stamps, and
// runs a bit-serial divider for the cadence, whose quotient is 13 bits wide
// at the default depth of 16. It waits in its done state until the output
// register is free. The stamp memory needs no clearing after reset. A
// finished report waits in the output register while the next sample is
// taken.

module peak_step_detector_cadence_core
  import psdc_pkg::*;
#(
  parameter int HISTORY_DEPTH = PSDC_HISTORY_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  psdc_sample_if.sink                 sample,
  psdc_report_if.source               report,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PSDC_ADDR_W-1:0] paddr,
  input  wire logic [PSDC_DATA_W-1:0] pwdata,
  output logic      [PSDC_DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int SPM_PER_STEP = PSDC_RATE_NUM / (2 * PSDC_MIN_SPAN);
  localparam int QW = $clog2((HISTORY_DEPTH - 1) * SPM_PER_STEP + 2);
  localparam int NW = (((FW + 17) > 32) ? (FW + 17) : 32) + 1;

  psdc_cfg_t   cfg;
  psdc_state_t state, state_next;

  // Detector state
  logic               peak_phase;
  logic signed [16:0] peak_value;
  logic [31:0]        last_step_time;
  logic [31:0]        total_count;
  logic [15:0]        walk_count, run_count, stairs_count, other_count;
  logic [HW-1:0]      ring_head;
  logic [FW-1:0]      ring_fill;

  // Per-item working registers
  logic [31:0]        now;
  logic               counted;
  logic [31:0]        newest_stamp;
  logic [31:0]        span;
  logic [7:0]         cad;

  // Memory and divider connections
  logic               ring_we;
  logic [HW-1:0]      ring_raddr;
  logic [31:0]        ring_rdata;
  logic               div_start;
  logic               div_done;
  logic [QW-1:0]      div_quo;
  logic [NW-1:0]      div_num;
  logic [PSDC_DEN_W-1:0] div_den;

  // Control outputs of the sequencer
  logic               take;
  logic               load_report;
  logic               sel_newest;

  // Configuration registers
  psdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Peak tracking on the incoming sample
  logic signed [16:0] dyn;
  logic signed [17:0] dyn2;
  logic [31:0]        since_step;
  logic               can_arm;
  logic               confirm;
  logic               act_ok;
  logic               count_now;

  assign dyn        = 17'(sample.vertical_accel) - PSDC_ONE_G;
  assign dyn2       = {dyn, 1'b0};
  assign since_step = sample.time_ms - last_step_time;
  assign can_arm    = (last_step_time == '0) || (since_step >= 32'(cfg.refractory_ms));
  assign confirm    = peak_phase && !(dyn > peak_value) &&
                      (dyn2 < $signed({3'b000, cfg.step_threshold}));
  assign act_ok     = (sample.activity_code != ACT_IDLE) &&
                      !((sample.activity_code >= ACT_FALL_LO) &&
                        (sample.activity_code <= ACT_FALL_HI));
  assign count_now  = confirm && act_ok;
  assign ring_we    = take && count_now;

  // Ring slot arithmetic
  logic [FW:0]   old_raw;
  logic [HW-1:0] oldest;
  logic [HW-1:0] newest;

  assign old_raw = (FW+1)'(ring_head) + (FW+1)'(HISTORY_DEPTH) - (FW+1)'(ring_fill);
  assign oldest  = (old_raw >= (FW+1)'(HISTORY_DEPTH)) ?
                   HW'(old_raw - (FW+1)'(HISTORY_DEPTH)) : HW'(old_raw);
  assign newest  = (ring_head == '0) ? HW'(HISTORY_DEPTH - 1) : ring_head - 1'b1;
  assign ring_raddr = sel_newest ? newest : oldest;

  psdc_ring #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (HW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_head),
    .wr_data (sample.time_ms),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  // Cadence tests
  logic        stale;
  logic        cad_off;
  logic [31:0] span_now;

  assign stale    = (now - ring_rdata) > 32'(cfg.stamp_window_ms);
  assign cad_off  = (last_step_time == '0) ||
                    ((now - last_step_time) > 32'(cfg.rate_timeout_ms)) ||
                    (ring_fill < FW'(2));
  assign span_now = newest_stamp - ring_rdata;

  assign div_num = NW'(FW'(ring_fill - 1'b1)) * NW'(PSDC_RATE_NUM) + NW'(span);
  assign div_den = {span, 1'b0};

  psdc_div #(
    .NUM_W (NW),
    .DEN_W (PSDC_DEN_W),
    .QUO_W (QW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (sample.valid) state_next = ST_PRUNE_RD;
      ST_PRUNE_RD:  state_next = (ring_fill == '0) ? ST_CAD_NEW : ST_PRUNE_CMP;
      ST_PRUNE_CMP: state_next = stale ? ST_PRUNE_RD : ST_CAD_NEW;
      ST_CAD_NEW:   state_next = cad_off ? ST_DONE : ST_CAD_OLD;
      ST_CAD_OLD:   state_next = ST_CAD_SPAN;
      ST_CAD_SPAN:  state_next = (span_now < PSDC_MIN_SPAN_MS) ? ST_DONE : ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_next = ST_DONE;
      ST_DONE:      if (!report.valid || report.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    sample.ready = 1'b0;
    sel_newest   = 1'b0;
    div_start    = 1'b0;
    load_report  = 1'b0;
    unique case (state)
      ST_IDLE:    sample.ready = 1'b1;
      ST_CAD_NEW: sel_newest   = 1'b1;
      ST_DIV_GO:  div_start    = 1'b1;
      ST_DONE:    load_report  = !report.valid || report.ready;
      default: ;
    endcase
  end

  assign take = sample.valid && sample.ready;

  // Detector state, counters and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_phase     <= 1'b0;
      peak_value     <= '0;
      last_step_time <= '0;
      total_count    <= '0;
      walk_count     <= '0;
      run_count      <= '0;
      stairs_count   <= '0;
      other_count    <= '0;
      ring_head      <= '0;
      ring_fill      <= '0;
    end else if (take) begin
      if (!peak_phase) begin
        if (can_arm && (dyn > $signed({2'b00, cfg.step_threshold}))) begin
          peak_phase <= 1'b1;
          peak_value <= dyn;
        end
      end else if (dyn > peak_value) begin
        peak_value <= dyn;
      end else if (confirm) begin
        peak_phase     <= 1'b0;
        last_step_time <= sample.time_ms;
      end
      if (count_now) begin
        total_count <= total_count + 1'b1;
        case (sample.activity_code)
          ACT_WALK:   walk_count   <= walk_count + 1'b1;
          ACT_RUN:    run_count    <= run_count + 1'b1;
          ACT_STAIRS: stairs_count <= stairs_count + 1'b1;
          default:    other_count  <= other_count + 1'b1;
        endcase
        ring_head <= (ring_head == HW'(HISTORY_DEPTH - 1)) ? '0 : ring_head + 1'b1;
        if (ring_fill < FW'(HISTORY_DEPTH)) begin
          ring_fill <= ring_fill + 1'b1;
        end
      end
    end else if ((state == ST_PRUNE_CMP) && stale) begin
      ring_fill <= ring_fill - 1'b1;
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (take) begin
      now     <= sample.time_ms;
      counted <= count_now;
      cad     <= '0;
    end
    if (state == ST_CAD_OLD) begin
      newest_stamp <= ring_rdata;
    end
    if (state == ST_CAD_SPAN) begin
      span <= span_now;
    end
    if ((state == ST_DIV_WAIT) && div_done) begin
      cad <= (div_quo > QW'(PSDC_CAD_MAX)) ? PSDC_CAD_MAX : div_quo[7:0];
    end
  end

  // Report output register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (load_report) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_report) begin
      report.step_counted <= counted;
      report.step_total   <= total_count;
      report.walk_total   <= walk_count;
      report.run_total    <= run_count;
      report.stairs_total <= stairs_count;
      report.other_steps  <= other_count;
      report.step_rate    <= cad;
    end
  end

endmodule

`default_nettype wire

[sim/peak_step_detector_cadence_checker.sv]
// Checker: predicts each step report from the observed samples and register writes.
`timescale 1ns / 1ps

module peak_step_detector_cadence_checker
  import psdc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  psdc_sample_if                      sample,
  psdc_report_if                      report,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic                   pready,
  input  wire logic [PSDC_ADDR_W-1:0] paddr,
  input  wire logic [PSDC_DATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          outstanding
);

  typedef struct packed {
    logic        step_counted;
    logic [31:0] step_total;
    logic [15:0] walk_total;
    logic [15:0] run_total;
    logic [15:0] stairs_total;
    logic [15:0] other_steps;
    logic [7:0]  step_rate;
  } step_report_t;

  // Shadow of the register file and of the detector state
  psdc_cfg_t          cfg;
  logic               in_peak;
  logic signed [16:0] peak_level;
  logic [31:0]        last_step_ms;
  logic [31:0]        total_cnt;
  logic [15:0]        walk_cnt;
  logic [15:0]        run_cnt;
  logic [15:0]        stairs_cnt;
  logic [15:0]        other_cnt;
  logic [31:0]        stamp_hist [PSDC_HISTORY_DEPTH];
  logic [3:0]         hist_head;
  logic [4:0]         hist_fill;

  step_report_t expected_reports[$];

  // Steps per minute over the stamps still held, rounded half up
  function automatic logic [7:0] step_rate_of(input logic [31:0] now);
    logic [31:0] span;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    if (last_step_ms == 0 || (now - last_step_ms) > 32'(cfg.rate_timeout_ms)) return 8'd0;
    if (hist_fill < 5'd2) return 8'd0;
    span = stamp_hist[hist_head - 4'd1] - stamp_hist[hist_head - hist_fill[3:0]];
    if (span < PSDC_MIN_SPAN_MS) return 8'd0;
    num = 64'(hist_fill - 5'd1) * 64'(PSDC_RATE_NUM) + 64'(span);
    den = {31'b0, span, 1'b0};
    quo = num / den;
    return (quo > 64'(PSDC_CAD_MAX)) ? PSDC_CAD_MAX : quo[7:0];
  endfunction

  // Advance the detector by one sample and build the report it yields
  task automatic predict_report(input logic signed [15:0] accel, input logic [3:0] act,
                                input logic [31:0] now, output step_report_t rep);
    int          dyn;
    logic        can_arm;
    logic        confirmed;
    logic        counted;
    logic [31:0] age;
    dyn = int'(accel) - int'(PSDC_ONE_G);
    can_arm = (last_step_ms == 0) || ((now - last_step_ms) >= 32'(cfg.refractory_ms));
    confirmed = 1'b0;
    counted = 1'b0;

    // armed / peak tracking
    if (!in_peak) begin
      if (can_arm && dyn > int'(cfg.step_threshold)) begin
        in_peak = 1'b1;
        peak_level = 17'(dyn);
      end
    end else if (dyn > int'(peak_level)) begin
      peak_level = 17'(dyn);
    end else if (2 * dyn < int'(cfg.step_threshold)) begin
      in_peak = 1'b0;
      last_step_ms = now;
      confirmed = 1'b1;
    end

    // idle and fall activity drop the step
    if (confirmed && act != ACT_IDLE && !(act >= ACT_FALL_LO && act <= ACT_FALL_HI)) begin
      counted = 1'b1;
      total_cnt++;
      case (act)
        ACT_WALK:   walk_cnt++;
        ACT_RUN:    run_cnt++;
        ACT_STAIRS: stairs_cnt++;
        default:    other_cnt++;
      endcase
      stamp_hist[hist_head] = now;
      hist_head++;
      if (hist_fill < 5'(PSDC_HISTORY_DEPTH)) hist_fill++;
    end

    // drop stale stamps from the oldest end
    while (hist_fill != 0) begin
      age = now - stamp_hist[hist_head - hist_fill[3:0]];
      if (age > 32'(cfg.stamp_window_ms)) hist_fill--;
      else break;
    end

    rep = '{counted, total_cnt, walk_cnt, run_cnt, stairs_cnt, other_cnt,
            step_rate_of(now)};
  endtask

  always @(posedge clk) begin : monitor
    step_report_t exp_rep;
    step_report_t got;
    if (rst) begin
      cfg = '{PSDC_THRESHOLD_RST, PSDC_REFRACTORY_RST, PSDC_WINDOW_RST, PSDC_TIMEOUT_RST};
      in_peak = 1'b0;
      peak_level = '0;
      last_step_ms = '0;
      total_cnt = '0;
      walk_cnt = '0;
      run_cnt = '0;
      stairs_cnt = '0;
      other_cnt = '0;
      hist_head = '0;
      hist_fill = '0;
      mismatches = 0;
      expected_reports.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (psdc_reg_t'(paddr[PSDC_ADDR_W-1:2]))
          REG_THRESHOLD:  cfg.step_threshold = pwdata[14:0];
          REG_REFRACTORY: cfg.refractory_ms = pwdata[15:0];
          REG_WINDOW:     cfg.stamp_window_ms = pwdata[15:0];
          REG_TIMEOUT:    cfg.rate_timeout_ms = pwdata[15:0];
          default: ;
        endcase
      end

      // sample transfer
      if (sample.valid && sample.ready) begin
        predict_report(sample.vertical_accel, sample.activity_code, sample.time_ms, exp_rep);
        expected_reports.push_back(exp_rep);
      end

      // report transfer
      if (report.valid && report.ready) begin
        got = '{report.step_counted, report.step_total, report.walk_total, report.run_total,
                report.stairs_total, report.other_steps, report.step_rate};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report with none expected: cnt=%0d tot=%0d cad=%0d",
                     $time, got.step_counted, got.step_total, got.step_rate);
        end else begin
          exp_rep = expected_reports.pop_front();
          if (got !== exp_rep) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected cnt=%0d tot=%0d walk=%0d run=%0d stairs=%0d other=%0d cad=%0d",
                       $time, exp_rep.step_counted, exp_rep.step_total, exp_rep.walk_total,
                       exp_rep.run_total, exp_rep.stairs_total, exp_rep.other_steps,
                       exp_rep.step_rate);
              $display("%0t: actual   cnt=%0d tot=%0d walk=%0d run=%0d stairs=%0d other=%0d cad=%0d",
                       $time, got.step_counted, got.step_total, got.walk_total,
                       got.run_total, got.stairs_total, got.other_steps, got.step_rate);
            end
          end
        end
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

[sim/peak_step_detector_cadence_core_test.sv]
// Testbench top: drives samples, register writes and back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module peak_step_detector_cadence_core_test;
  import psdc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam logic signed [15:0] ACCEL_MAX = 16'sh7FFF;
  localparam logic signed [15:0] ACCEL_MIN = 16'sh8000;
  localparam logic [3:0] ACT_OTHER_LO = 4'd8;
  localparam logic [3:0] ACT_OTHER_HI = 4'd15;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PSDC_ADDR_W-1:0] paddr;
  logic [PSDC_DATA_W-1:0] pwdata;
  logic [PSDC_DATA_W-1:0] prdata;
  logic                   pready;

  int          mismatches;
  int          outstanding;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_request;
  int          items_sent;
  logic [31:0] clock_ms;

  psdc_sample_if sample_ch ();
  psdc_report_if report_ch ();

  peak_step_detector_cadence_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .report  (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  peak_step_detector_cadence_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .report      (report_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL peak_step_detector_cadence_core");
    $finish;
  end

  // Report receiver: random stalls plus an occasional long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Gravity-removed value back to a clamped raw sample
  function automatic logic signed [15:0] accel_of(input int dyn);
    int raw;
    raw = dyn + int'(PSDC_ONE_G);
    if (raw > 32767) raw = 32767;
    if (raw < -32768) raw = -32768;
    return 16'(raw);
  endfunction

  // One sample transfer; called and returns at a falling edge
  task automatic send_sample(input logic signed [15:0] accel, input logic [3:0] act,
                             input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.vertical_accel <= accel;
    sample_ch.activity_code <= act;
    sample_ch.time_ms <= now;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Setup then access cycle; psel stays up for back-to-back writes
  task automatic apb_write(input psdc_reg_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain the block, then write all four registers
  task automatic configure(input logic [14:0] thr, input logic [15:0] refr,
                           input logic [15:0] win, input logic [15:0] tmo);
    sample_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_write(REG_THRESHOLD, 32'(thr));
    apb_write(REG_REFRACTORY, 32'(refr));
    apb_write(REG_WINDOW, 32'(win));
    apb_write(REG_TIMEOUT, 32'(tmo));
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed step waveforms, with noise, broken steps and long silences
  task automatic run_phase(input logic [14:0] thr, input logic [15:0] refr,
                           input logic [15:0] win, input logic [15:0] tmo, input int count,
                           input int snd_pct, input int rcv_pct, input bit long_hold);
    int         start;
    int         kind;
    int         sel;
    int         gap;
    int         dt;
    int         thr_i;
    int         rise_dyn;
    int         fall_dyn;
    logic [3:0] act;
    configure(thr, refr, win, tmo);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    if (long_hold) hold_request = LONG_HOLD_CYCLES;
    thr_i = int'(thr);
    clock_ms = $urandom();
    start = items_sent;
    while (items_sent - start < count) begin
      kind = $urandom_range(99);
      if (kind < 78) begin
        // gap since the last step: mostly past refractory
        sel = $urandom_range(99);
        if (sel < 60) gap = int'(refr) + int'($urandom_range(0, 400));
        else if (sel < 80) gap = int'($urandom_range(0, int'(refr)));
        else gap = int'($urandom_range(0, 70000));
        clock_ms += 32'(gap);
        // activity mostly a counting one
        if ($urandom_range(9) < 7) begin
          case ($urandom_range(3))
            0: act = ACT_WALK;
            1: act = ACT_RUN;
            2: act = ACT_STAIRS;
            default: act = 4'($urandom_range(ACT_OTHER_LO, ACT_OTHER_HI));
          endcase
        end else begin
          act = 4'($urandom());
        end
        dt = $urandom_range(2, 40);
        repeat ($urandom_range(0, 2)) begin
          clock_ms += 32'(dt);
          send_sample(accel_of(int'($urandom_range(0, 600)) - 300), act, clock_ms);
        end
        // rise over threshold, maybe a higher peak
        rise_dyn = thr_i + 1 + int'($urandom_range(0, 3000));
        clock_ms += 32'(dt);
        send_sample(accel_of(rise_dyn), act, clock_ms);
        if ($urandom_range(1) == 1) begin
          clock_ms += 32'(dt);
          send_sample(accel_of(rise_dyn + int'($urandom_range(1, 4000))), act, clock_ms);
        end
        // at or above half threshold: no confirm yet
        repeat ($urandom_range(0, 2)) begin
          clock_ms += 32'(dt);
          send_sample(accel_of(((thr_i + 1) >>> 1) + int'($urandom_range(0, 200))), act,
                      clock_ms);
        end
        // fall below half threshold, sometimes right at the edge
        if ($urandom_range(2) == 0) fall_dyn = (thr_i - 1) >>> 1;
        else fall_dyn = (thr_i >>> 1) - 1 - int'($urandom_range(0, 8000));
        clock_ms += 32'(dt);
        send_sample(accel_of(fall_dyn), act, clock_ms);
      end else if (kind < 92) begin
        // noise over the full field ranges
        sel = $urandom_range(9);
        if (sel < 8) clock_ms += $urandom_range(0, 500);
        else if (sel == 8) clock_ms = $urandom();
        else clock_ms = '0;
        send_sample(16'($urandom()), 4'($urandom()), clock_ms);
      end else if (kind < 96) begin
        // armed, then left hanging across a long gap
        clock_ms += 32'(refr) + $urandom_range(0, 200);
        send_sample(accel_of(thr_i + 1 + int'($urandom_range(0, 3000))), 4'($urandom()),
                    clock_ms);
        clock_ms += $urandom_range(0, 100000);
        send_sample(accel_of(((thr_i + 1) >>> 1) + int'($urandom_range(0, 200))),
                    4'($urandom()), clock_ms);
      end else begin
        // long silence to let stamps go stale
        clock_ms += $urandom_range(0, 70000);
        send_sample(accel_of(int'($urandom_range(0, 400)) - 200), 4'($urandom()), clock_ms);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.vertical_accel = '0;
    sample_ch.activity_code = ACT_IDLE;
    sample_ch.time_ms = '0;
    send_idle_pct = 9;
    recv_idle_pct = 70;
    hold_request = 0;
    items_sent = 0;
    clock_ms = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, exact half-threshold edge, every activity class
    send_sample(accel_of(0), ACT_WALK, 32'd100);
    send_sample(ACCEL_MAX, ACT_WALK, 32'd110);
    send_sample(accel_of(615), ACT_WALK, 32'd120);
    send_sample(accel_of(614), ACT_WALK, 32'd130);
    send_sample(ACCEL_MAX, ACT_RUN, 32'd140);         // inside refractory gap
    send_sample(accel_of(2000), ACT_RUN, 32'd500);
    send_sample(accel_of(3000), ACT_RUN, 32'd505);    // peak climbs
    send_sample(ACCEL_MIN, ACT_RUN, 32'd510);
    send_sample(ACCEL_MAX, ACT_STAIRS, 32'd900);
    send_sample(ACCEL_MIN, ACT_STAIRS, 32'd910);
    send_sample(ACCEL_MAX, ACT_OTHER_LO, 32'd1300);
    send_sample(ACCEL_MIN, ACT_OTHER_LO, 32'd1310);
    send_sample(ACCEL_MAX, ACT_OTHER_HI, 32'd1700);
    send_sample(ACCEL_MIN, ACT_OTHER_HI, 32'd1710);
    // dismissed under idle and fall
    send_sample(ACCEL_MAX, ACT_WALK, 32'd2100);
    send_sample(ACCEL_MIN, ACT_IDLE, 32'd2110);
    send_sample(ACCEL_MAX, ACT_WALK, 32'd2500);
    send_sample(ACCEL_MIN, ACT_FALL_LO, 32'd2510);
    send_sample(ACCEL_MAX, ACT_WALK, 32'd2900);
    send_sample(ACCEL_MIN, ACT_FALL_HI, 32'd2910);
    // cadence timeout
    send_sample(accel_of(0), ACT_WALK, 32'd9000);
    // step stamped at time zero across the wrap, then no refractory
    send_sample(ACCEL_MAX, ACT_WALK, 32'hFFFF_FF00);
    send_sample(ACCEL_MIN, ACT_WALK, 32'd0);
    send_sample(ACCEL_MAX, ACT_RUN, 32'd5);
    send_sample(ACCEL_MIN, ACT_RUN, 32'd10);

    // Random phases across register settings and idle patterns
    run_phase(PSDC_THRESHOLD_RST, PSDC_REFRACTORY_RST, PSDC_WINDOW_RST, PSDC_TIMEOUT_RST,
              320, 9, 70, 1'b0);
    run_phase(15'd206, 16'd51, 16'd1000, 16'd500, 320, 9, 70, 1'b1);
    run_phase(15'd2000, 16'd65535, 16'd65535, 16'd65535, 250, 70, 9, 1'b0);
    run_phase(15'd32767, 16'd300, 16'd65535, 16'd500, 100, 70, 9, 1'b0);
    run_phase(15'd0, 16'd0, 16'd0, 16'd0, 150, 0, 0, 1'b0);   // below range, no fallback
    run_phase(15'($urandom_range(206, 4000)), 16'($urandom_range(51, 600)),
              16'($urandom_range(1000, 20000)), 16'($urandom_range(500, 5000)),
              460, 0, 0, 1'b1);

    // Drain and decide
    sample_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS peak_step_detector_cadence_core");
    end else begin
      $display("FAIL peak_step_detector_cadence_core");
    end
    $finish;
  end

endmodule
